FILE: rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants, types and the CORDIC arctangent table for the scan point
// reprojection datapath.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ROT_W        = 33;   // rotation x/y, Q1.30 plus headroom
   localparam int VEC_W        = 46;   // vectoring x/y, Q16.24 plus growth
   localparam int ROT_SIDE_W   = 35;   // last, sat, flip, dd[31:0]
   localparam int VEC_SIDE_W   = 3;    // last, sat, zero
   localparam int CSR_ADDR_W   = 5;

   localparam logic signed [ROT_W-1:0] K_Q30 = 33'sd652032874;
   localparam logic [19:0]             K_Q20 = 20'd636752;

   typedef enum logic [2:0] {
      REG_OFFSET_X         = 3'd0,
      REG_OFFSET_Y         = 3'd1,
      REG_BASE_HEADING     = 3'd2,
      REG_TARGET_HEADING   = 3'd3,
      REG_ANGLE_GAIN       = 3'd4,
      REG_ANGLE_GAIN_RECIP = 3'd5,
      REG_DIST_GAIN        = 3'd6,
      REG_DIST_GAIN_RECIP  = 3'd7
   } reg_index_type;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051D;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2F9;
         15: v = 32'h0000517C;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A2F;
         19: v = 32'h00000517;
         20: v = 32'h0000028B;
         21: v = 32'h00000145;
         22: v = 32'h000000A2;
         23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/spr_req_if.sv
// ----------------------------------------------------------------------------
// spr_req_if
// Scan point input channel: valid/ready with one raw point per item.
// ----------------------------------------------------------------------------
interface spr_req_if #(
   parameter int ANGLE_BITS = 16,
   parameter int DIST_BITS  = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle_raw;
   logic [DIST_BITS-1:0]         distance_raw;
   logic                         last_point;

   modport source (output valid, angle_raw, distance_raw, last_point, input ready);
   modport sink   (input valid, angle_raw, distance_raw, last_point, output ready);
endinterface

FILE: rtl/core/spr_rsp_if.sv
// ----------------------------------------------------------------------------
// spr_rsp_if
// Reprojected point output channel: valid/ready with one result per item.
// ----------------------------------------------------------------------------
interface spr_rsp_if #(
   parameter int ANGLE_BITS = 16,
   parameter int DIST_BITS  = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] new_angle_raw;
   logic [DIST_BITS-1:0]         new_distance_raw;
   logic                         saturated;
   logic                         last_out;

   modport source (output valid, new_angle_raw, new_distance_raw, saturated, last_out,
                   input ready);
   modport sink   (input valid, new_angle_raw, new_distance_raw, saturated, last_out,
                   output ready);
endinterface

FILE: rtl/core/spr_cordic_cell.sv
// ----------------------------------------------------------------------------
// spr_cordic_cell
// One registered CORDIC micro-rotation; rotation or vectoring mode, with a
// side payload that travels alongside unchanged.
// ----------------------------------------------------------------------------
module spr_cordic_cell
   import spr_pkg::*;
#(
   parameter int STEP   = 0,
   parameter int W      = 33,
   parameter int SIDE_W = 1,
   parameter bit VECTOR = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                up_valid,
   input  logic signed [W-1:0] up_x,
   input  logic signed [W-1:0] up_y,
   input  logic [31:0]         up_z,
   input  logic [SIDE_W-1:0]   up_side,
   output logic                valid_ff,
   output logic signed [W-1:0] x_ff,
   output logic signed [W-1:0] y_ff,
   output logic [31:0]         z_ff,
   output logic [SIDE_W-1:0]   side_ff
);

   localparam logic [31:0] ATAN = atan_turn(STEP);

   logic                sigma_pos;
   logic signed [W-1:0] xs, ys;
   logic signed [W-1:0] x_in, y_in;
   logic [31:0]         z_in;

   // rotation drives z toward zero, vectoring drives y toward zero
   assign sigma_pos = VECTOR ? up_y[W-1] : !up_z[31];
   assign xs = up_x >>> STEP;
   assign ys = up_y >>> STEP;

   always_comb begin
      if (sigma_pos) begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         z_in = up_z - ATAN;
      end else begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         z_in = up_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= up_side;
      end
   end

endmodule

FILE: rtl/core/scan_point_reprojection.sv
// Throughput: one item per cycle; two chains of 24 CORDIC cells, each cell one
// micro-rotation per cycle, with registered multiply stages before, between and after them.
// The whole pipeline holds while a result waits on rsp and rsp.ready is low.
// Reset (synchronous, active high) empties the pipeline and sets offsets and
// headings to zero and all gains to 1.0.
// ----------------------------------------------------------------------------
// scan_point_reprojection
// Re-expresses polar scan points from a base pose as seen from a target pose.
// ----------------------------------------------------------------------------
module scan_point_reprojection
   import spr_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int DIST_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   spr_req_if.sink               req,
   spr_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic signed [24:0] AMAX = (25'sd1 <<< (ANGLE_BITS - 1)) - 25'sd1;
   localparam logic signed [24:0] AMIN = -AMAX - 25'sd1;
   localparam logic [28:0]        DMAX = (29'd1 << DIST_BITS) - 29'd1;

   // configuration registers
   logic signed [31:0] offset_x_ff, offset_y_ff;
   logic [15:0]        base_heading_ff, target_heading_ff;
   logic [31:0]        angle_gain_ff, angle_gain_recip_ff;
   logic [31:0]        dist_gain_ff, dist_gain_recip_ff;
   reg_index_type      csr_idx;
   logic               csr_wr;

   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff         <= '0;
         offset_y_ff         <= '0;
         base_heading_ff     <= '0;
         target_heading_ff   <= '0;
         angle_gain_ff       <= 32'd16777216;
         angle_gain_recip_ff <= 32'd16777216;
         dist_gain_ff        <= 32'd16777216;
         dist_gain_recip_ff  <= 32'd16777216;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_OFFSET_X:         offset_x_ff         <= csr_pwdata;
            REG_OFFSET_Y:         offset_y_ff         <= csr_pwdata;
            REG_BASE_HEADING:     base_heading_ff     <= csr_pwdata[15:0];
            REG_TARGET_HEADING:   target_heading_ff   <= csr_pwdata[15:0];
            REG_ANGLE_GAIN:       angle_gain_ff       <= csr_pwdata;
            REG_ANGLE_GAIN_RECIP: angle_gain_recip_ff <= csr_pwdata;
            REG_DIST_GAIN:        dist_gain_ff        <= csr_pwdata;
            REG_DIST_GAIN_RECIP:  dist_gain_recip_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_OFFSET_X:         csr_prdata = offset_x_ff;
         REG_OFFSET_Y:         csr_prdata = offset_y_ff;
         REG_BASE_HEADING:     csr_prdata = {16'd0, base_heading_ff};
         REG_TARGET_HEADING:   csr_prdata = {16'd0, target_heading_ff};
         REG_ANGLE_GAIN:       csr_prdata = angle_gain_ff;
         REG_ANGLE_GAIN_RECIP: csr_prdata = angle_gain_recip_ff;
         REG_DIST_GAIN:        csr_prdata = dist_gain_ff;
         REG_DIST_GAIN_RECIP:  csr_prdata = dist_gain_recip_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // pipeline advances unless a result is held on rsp
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 1: gain products
   logic                         p1_valid_ff, p1_last_ff;
   logic signed [ANGLE_BITS+32:0] p1_aprod_ff;
   logic [DIST_BITS+31:0]        p1_dprod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_aprod_ff <= $signed(req.angle_raw) * $signed({1'b0, angle_gain_ff});
         p1_dprod_ff <= req.distance_raw * dist_gain_ff;
         p1_last_ff  <= req.last_point;
      end
   end

   // stage 2: binary angle, scaled range, rotation set-up
   logic [15:0]             theta;
   logic [31:0]             z_init;
   logic                    flip, dd_clip;
   logic [31:0]             dd;
   logic                    p2_valid_ff;
   logic [31:0]             p2_z_ff;
   logic [ROT_SIDE_W-1:0]   p2_side_ff;

   assign theta   = p1_aprod_ff[39:24] + base_heading_ff;
   assign flip    = theta[15] ^ theta[14];
   assign z_init  = {theta[15] ^ flip, theta[14:0], 16'd0};
   assign dd_clip = |p1_dprod_ff[DIST_BITS+31:40];
   assign dd      = dd_clip ? 32'hFFFF_FFFF : p1_dprod_ff[39:8];

   always_ff @(posedge clock) begin
      if (en) begin
         p2_z_ff    <= z_init;
         p2_side_ff <= {p1_last_ff, dd_clip, flip, dd};
      end
   end

   // rotation chain: cos/sin of theta in Q1.30
   logic                  rot_v    [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0] rot_x  [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0] rot_y  [0:CORDIC_STEPS];
   logic [31:0]           rot_z    [0:CORDIC_STEPS];
   logic [ROT_SIDE_W-1:0] rot_side [0:CORDIC_STEPS];

   assign rot_v[0]    = p2_valid_ff;
   assign rot_x[0]    = K_Q30;
   assign rot_y[0]    = '0;
   assign rot_z[0]    = p2_z_ff;
   assign rot_side[0] = p2_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      spr_cordic_cell #(
         .STEP(i), .W(ROT_W), .SIDE_W(ROT_SIDE_W), .VECTOR(1'b0)
      ) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_valid(rot_v[i]), .up_x(rot_x[i]), .up_y(rot_y[i]),
         .up_z(rot_z[i]), .up_side(rot_side[i]),
         .valid_ff(rot_v[i+1]), .x_ff(rot_x[i+1]), .y_ff(rot_y[i+1]),
         .z_ff(rot_z[i+1]), .side_ff(rot_side[i+1])
      );
   end

   // stage 3: range times cos/sin
   logic signed [ROT_W-1:0]   cos_v, sin_v;
   logic                      rot_flip;
   logic [31:0]               rot_dd;
   logic                      p3_valid_ff, p3_last_ff, p3_sat_ff;
   logic signed [2*ROT_W-1:0] p3_pc_ff, p3_ps_ff;

   assign rot_flip = rot_side[CORDIC_STEPS][32];
   assign rot_dd   = rot_side[CORDIC_STEPS][31:0];
   assign cos_v    = rot_flip ? -rot_x[CORDIC_STEPS] : rot_x[CORDIC_STEPS];
   assign sin_v    = rot_flip ? -rot_y[CORDIC_STEPS] : rot_y[CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         p3_pc_ff   <= $signed({1'b0, rot_dd}) * cos_v;
         p3_ps_ff   <= $signed({1'b0, rot_dd}) * sin_v;
         p3_last_ff <= rot_side[CORDIC_STEPS][34];
         p3_sat_ff  <= rot_side[CORDIC_STEPS][33];
      end
   end

   // stage 4: add pose offset, Q16.16
   logic                p4_valid_ff, p4_last_ff, p4_sat_ff;
   logic signed [35:0]  p4_x_ff, p4_y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p4_x_ff    <= $signed(p3_pc_ff[65:30]) + 36'(offset_x_ff);
         p4_y_ff    <= $signed(p3_ps_ff[65:30]) + 36'(offset_y_ff);
         p4_last_ff <= p3_last_ff;
         p4_sat_ff  <= p3_sat_ff;
      end
   end

   // stage 5: vectoring set-up, fold left half-plane onto the right
   logic signed [VEC_W-1:0] vx, vy;
   logic                    p5_valid_ff;
   logic signed [VEC_W-1:0] p5_x_ff, p5_y_ff;
   logic [31:0]             p5_z_ff;
   logic [VEC_SIDE_W-1:0]   p5_side_ff;

   assign vx = {{2{p4_x_ff[35]}}, p4_x_ff, 8'd0};
   assign vy = {{2{p4_y_ff[35]}}, p4_y_ff, 8'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         p5_x_ff    <= p4_x_ff[35] ? -vx : vx;
         p5_y_ff    <= p4_x_ff[35] ? -vy : vy;
         p5_z_ff    <= p4_x_ff[35] ? 32'h8000_0000 : 32'd0;
         p5_side_ff <= {p4_last_ff, p4_sat_ff, (p4_x_ff == '0) && (p4_y_ff == '0)};
      end
   end

   logic                    vec_v    [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] vec_x    [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] vec_y    [0:CORDIC_STEPS];
   logic [31:0]             vec_z    [0:CORDIC_STEPS];
   logic [VEC_SIDE_W-1:0]   vec_side [0:CORDIC_STEPS];

   assign vec_v[0]    = p5_valid_ff;
   assign vec_x[0]    = p5_x_ff;
   assign vec_y[0]    = p5_y_ff;
   assign vec_z[0]    = p5_z_ff;
   assign vec_side[0] = p5_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      spr_cordic_cell #(
         .STEP(i), .W(VEC_W), .SIDE_W(VEC_SIDE_W), .VECTOR(1'b1)
      ) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_valid(vec_v[i]), .up_x(vec_x[i]), .up_y(vec_y[i]),
         .up_z(vec_z[i]), .up_side(vec_side[i]),
         .valid_ff(vec_v[i+1]), .x_ff(vec_x[i+1]), .y_ff(vec_y[i+1]),
         .z_ff(vec_z[i+1]), .side_ff(vec_side[i+1])
      );
   end

   // stage 6: relative bearing, magnitude gain product
   logic [31:0]        ang;
   logic               p6_valid_ff, p6_last_ff, p6_sat_ff;
   logic signed [15:0] p6_rel_ff;
   logic [63:0]        p6_mprod_ff;

   assign ang = vec_side[CORDIC_STEPS][0] ? 32'd0 : vec_z[CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         p6_rel_ff   <= ang[31:16] - target_heading_ff;
         p6_mprod_ff <= vec_x[CORDIC_STEPS][44:0] * K_Q20;
         p6_last_ff  <= vec_side[CORDIC_STEPS][2];
         p6_sat_ff   <= vec_side[CORDIC_STEPS][1];
      end
   end

   // stage 7: rescale to raw counts
   logic [35:0]        mag;
   logic               p7_valid_ff, p7_last_ff, p7_sat_ff;
   logic [51:0]        p7_mh_ff, p7_ml_ff;
   logic signed [48:0] p7_na_ff;

   assign mag = p6_mprod_ff[63:28];

   always_ff @(posedge clock) begin
      if (en) begin
         p7_mh_ff   <= mag * dist_gain_recip_ff[31:16];
         p7_ml_ff   <= mag * dist_gain_recip_ff[15:0];
         p7_na_ff   <= p6_rel_ff * $signed({1'b0, angle_gain_recip_ff});
         p7_last_ff <= p6_last_ff;
         p7_sat_ff  <= p6_sat_ff;
      end
   end

   // stage 8: saturate into the output register
   logic [52:0]                  nd_sum;
   logic [28:0]                  nd;
   logic signed [24:0]           na;
   logic                         na_hi, na_lo, nd_hi;
   logic signed [ANGLE_BITS-1:0] angle_out;
   logic [DIST_BITS-1:0]         dist_out;
   logic signed [ANGLE_BITS-1:0] rsp_angle_ff;
   logic [DIST_BITS-1:0]         rsp_dist_ff;
   logic                         rsp_sat_ff, rsp_last_ff;

   assign nd_sum    = {1'b0, p7_mh_ff} + 53'(p7_ml_ff >> 16);
   assign nd        = nd_sum[52:24];
   assign na        = p7_na_ff[48:24];
   assign na_hi     = na > AMAX;
   assign na_lo     = na < AMIN;
   assign nd_hi     = nd > DMAX;
   assign angle_out = na_hi ? AMAX[ANGLE_BITS-1:0] :
                      na_lo ? AMIN[ANGLE_BITS-1:0] : na[ANGLE_BITS-1:0];
   assign dist_out  = nd_hi ? DMAX[DIST_BITS-1:0] : nd[DIST_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_angle_ff <= angle_out;
         rsp_dist_ff  <= dist_out;
         rsp_sat_ff   <= p7_sat_ff || na_hi || na_lo || nd_hi;
         rsp_last_ff  <= p7_last_ff;
      end
   end

   // valid bits of the non-cell stages
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         p6_valid_ff  <= 1'b0;
         p7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff  <= req.valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= rot_v[CORDIC_STEPS];
         p4_valid_ff  <= p3_valid_ff;
         p5_valid_ff  <= p4_valid_ff;
         p6_valid_ff  <= vec_v[CORDIC_STEPS];
         p7_valid_ff  <= p6_valid_ff;
         rsp_valid_ff <= p7_valid_ff;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.new_angle_raw    = rsp_angle_ff;
   assign rsp.new_distance_raw = rsp_dist_ff;
   assign rsp.saturated        = rsp_sat_ff;
   assign rsp.last_out         = rsp_last_ff;

endmodule

FILE: rtl/core/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the reprojection block's handshakes.
// ----------------------------------------------------------------------------
module spr_checker #(
   parameter int ANGLE_BITS = 16,
   parameter int DIST_BITS  = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ANGLE_BITS-1:0] rsp_angle,
   input logic [DIST_BITS-1:0]  rsp_dist
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_angle) && $stable(rsp_dist))
      else $error("rsp payload changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a stalled output holds the whole pipeline, input included
   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while output stalled");

   // ready follows only the output side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind scan_point_reprojection spr_checker #(
   .ANGLE_BITS(ANGLE_BITS), .DIST_BITS(DIST_BITS)
) u_spr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_angle(rsp.new_angle_raw),
   .rsp_dist(rsp.new_distance_raw)
);
